>>> src/npcs_pkg.sv
// shared types, constants and the fixed vga palette table for the palette search
// no dependencies
`default_nettype none

package npcs_pkg;

  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CROSS_W    = 3 * MUL_W;
  localparam int PAL_USED   = 168;
  localparam int SHORT_DEPTH = 16;

  localparam logic [COLOR_W-1:0] NO_MATCH_INDEX = 8'hFF;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PALETTE_SELECT = 2'd0;
  localparam cfg_idx_t CFG_DISTANCE_MODE  = 2'd1;

  typedef logic [3:0] step_t;

  // euclidean sequence, one entry
  localparam step_t EU_SQ_R = 4'd0;
  localparam step_t EU_SQ_G = 4'd1;
  localparam step_t EU_SQ_B = 4'd2;
  localparam step_t EU_SUM  = 4'd3;

  // cosine sequence, one entry
  localparam step_t CO_MAG_R   = 4'd0;
  localparam step_t CO_MAG_G   = 4'd1;
  localparam step_t CO_MAG_B   = 4'd2;
  localparam step_t CO_DOT_R   = 4'd3;
  localparam step_t CO_DOT_G   = 4'd4;
  localparam step_t CO_DOT_B   = 4'd5;
  localparam step_t CO_DOT_SUM = 4'd6;
  localparam step_t CO_DOT_SQ  = 4'd7;
  localparam step_t CO_LHS_LO  = 4'd8;
  localparam step_t CO_LHS_HI  = 4'd9;
  localparam step_t CO_RHS_LO  = 4'd10;
  localparam step_t CO_RHS_HI  = 4'd11;
  localparam step_t CO_CMP     = 4'd12;

  typedef struct packed {
    step_t step;
    logic  cosine;
    logic  found;
  } dist_ctrl_t;

  // entries past the table are black
  localparam logic [RGB_W-1:0] PAL_ROM [0:PAL_USED-1] = '{
    {8'd0,8'd0,8'd0},       {8'd0,8'd0,8'd170},     {8'd0,8'd170,8'd0},     {8'd0,8'd170,8'd170},
    {8'd170,8'd0,8'd0},     {8'd170,8'd0,8'd170},   {8'd170,8'd85,8'd0},    {8'd170,8'd170,8'd170},
    {8'd85,8'd85,8'd85},    {8'd85,8'd85,8'd255},   {8'd85,8'd255,8'd85},   {8'd85,8'd255,8'd255},
    {8'd255,8'd85,8'd85},   {8'd255,8'd85,8'd255},  {8'd255,8'd255,8'd85},  {8'd255,8'd255,8'd255},
    {8'd0,8'd0,8'd0},       {8'd20,8'd20,8'd20},    {8'd32,8'd32,8'd32},    {8'd44,8'd44,8'd44},
    {8'd56,8'd56,8'd56},    {8'd68,8'd68,8'd68},    {8'd80,8'd80,8'd80},    {8'd96,8'd96,8'd96},
    {8'd112,8'd112,8'd112}, {8'd128,8'd128,8'd128}, {8'd144,8'd144,8'd144}, {8'd160,8'd160,8'd160},
    {8'd180,8'd180,8'd180}, {8'd200,8'd200,8'd200}, {8'd224,8'd224,8'd224}, {8'd252,8'd252,8'd252},
    {8'd0,8'd0,8'd252},     {8'd64,8'd0,8'd252},    {8'd124,8'd0,8'd252},   {8'd188,8'd0,8'd252},
    {8'd252,8'd0,8'd252},   {8'd252,8'd0,8'd188},   {8'd252,8'd0,8'd124},   {8'd252,8'd0,8'd64},
    {8'd252,8'd0,8'd0},     {8'd252,8'd64,8'd0},    {8'd252,8'd124,8'd0},   {8'd252,8'd188,8'd0},
    {8'd252,8'd252,8'd0},   {8'd188,8'd252,8'd0},   {8'd124,8'd252,8'd0},   {8'd64,8'd252,8'd0},
    {8'd0,8'd252,8'd0},     {8'd0,8'd252,8'd64},    {8'd0,8'd252,8'd124},   {8'd0,8'd252,8'd188},
    {8'd0,8'd252,8'd252},   {8'd0,8'd188,8'd252},   {8'd0,8'd124,8'd252},   {8'd0,8'd64,8'd252},
    {8'd124,8'd124,8'd252}, {8'd156,8'd124,8'd252}, {8'd188,8'd124,8'd252}, {8'd220,8'd124,8'd252},
    {8'd252,8'd124,8'd252}, {8'd252,8'd124,8'd220}, {8'd252,8'd124,8'd188}, {8'd252,8'd124,8'd156},
    {8'd252,8'd124,8'd124}, {8'd252,8'd156,8'd124}, {8'd252,8'd188,8'd124}, {8'd252,8'd220,8'd124},
    {8'd252,8'd252,8'd124}, {8'd220,8'd252,8'd124}, {8'd188,8'd252,8'd124}, {8'd156,8'd252,8'd124},
    {8'd124,8'd252,8'd124}, {8'd124,8'd252,8'd156}, {8'd124,8'd252,8'd188}, {8'd124,8'd252,8'd220},
    {8'd124,8'd252,8'd252}, {8'd124,8'd220,8'd252}, {8'd124,8'd188,8'd252}, {8'd124,8'd156,8'd252},
    {8'd180,8'd180,8'd252}, {8'd196,8'd180,8'd252}, {8'd220,8'd180,8'd252}, {8'd236,8'd180,8'd252},
    {8'd252,8'd180,8'd252}, {8'd252,8'd180,8'd236}, {8'd252,8'd180,8'd220}, {8'd252,8'd180,8'd196},
    {8'd252,8'd180,8'd180}, {8'd252,8'd196,8'd180}, {8'd252,8'd220,8'd180}, {8'd252,8'd236,8'd180},
    {8'd252,8'd252,8'd180}, {8'd236,8'd252,8'd180}, {8'd220,8'd252,8'd180}, {8'd196,8'd252,8'd180},
    {8'd180,8'd252,8'd180}, {8'd180,8'd252,8'd196}, {8'd180,8'd252,8'd220}, {8'd180,8'd252,8'd236},
    {8'd180,8'd252,8'd252}, {8'd180,8'd236,8'd252}, {8'd180,8'd220,8'd252}, {8'd180,8'd196,8'd252},
    {8'd0,8'd0,8'd112},     {8'd28,8'd0,8'd112},    {8'd56,8'd0,8'd112},    {8'd84,8'd0,8'd112},
    {8'd112,8'd0,8'd112},   {8'd112,8'd0,8'd84},    {8'd112,8'd0,8'd56},    {8'd112,8'd0,8'd28},
    {8'd112,8'd0,8'd0},     {8'd112,8'd28,8'd0},    {8'd112,8'd56,8'd0},    {8'd112,8'd84,8'd0},
    {8'd112,8'd112,8'd0},   {8'd84,8'd112,8'd0},    {8'd56,8'd112,8'd0},    {8'd28,8'd112,8'd0},
    {8'd0,8'd112,8'd0},     {8'd0,8'd112,8'd28},    {8'd0,8'd112,8'd56},    {8'd0,8'd112,8'd84},
    {8'd0,8'd112,8'd112},   {8'd0,8'd84,8'd112},    {8'd0,8'd56,8'd112},    {8'd0,8'd28,8'd112},
    {8'd56,8'd56,8'd112},   {8'd68,8'd56,8'd112},   {8'd84,8'd56,8'd112},   {8'd96,8'd56,8'd112},
    {8'd112,8'd56,8'd112},  {8'd112,8'd56,8'd96},   {8'd112,8'd56,8'd84},   {8'd112,8'd56,8'd68},
    {8'd112,8'd56,8'd56},   {8'd112,8'd68,8'd56},   {8'd112,8'd84,8'd56},   {8'd112,8'd96,8'd56},
    {8'd112,8'd112,8'd56},  {8'd96,8'd112,8'd56},   {8'd84,8'd112,8'd56},   {8'd68,8'd112,8'd56},
    {8'd56,8'd112,8'd56},   {8'd56,8'd112,8'd68},   {8'd56,8'd112,8'd84},   {8'd56,8'd112,8'd96},
    {8'd56,8'd112,8'd112},  {8'd56,8'd96,8'd112},   {8'd56,8'd84,8'd112},   {8'd56,8'd68,8'd112},
    {8'd0,8'd0,8'd0},       {8'd16,8'd16,8'd16},    {8'd32,8'd32,8'd32},    {8'd48,8'd48,8'd48},
    {8'd64,8'd64,8'd64},    {8'd80,8'd80,8'd80},    {8'd96,8'd96,8'd96},    {8'd112,8'd112,8'd112},
    {8'd128,8'd128,8'd128}, {8'd144,8'd144,8'd144}, {8'd160,8'd160,8'd160}, {8'd176,8'd176,8'd176},
    {8'd192,8'd192,8'd192}, {8'd208,8'd208,8'd208}, {8'd224,8'd224,8'd224}, {8'd240,8'd240,8'd240}
  };

  function automatic logic [RGB_W-1:0] palette_color(input logic [COLOR_W-1:0] idx);
    logic [RGB_W-1:0] c;
    c = '0;
    if (idx < COLOR_W'(PAL_USED)) begin
      c = PAL_ROM[idx];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/npcs_dist_unit.sv
// shared 18x18 multiplier with accumulators and best-so-far compare for one palette entry
// depends on npcs_pkg
`default_nettype none

module npcs_dist_unit (
  input  logic                              clk,
  input  npcs_pkg::dist_ctrl_t              ctrl,
  input  logic [npcs_pkg::COLOR_W-1:0]      pixel_red,
  input  logic [npcs_pkg::COLOR_W-1:0]      pixel_green,
  input  logic [npcs_pkg::COLOR_W-1:0]      pixel_blue,
  input  logic [npcs_pkg::RGB_W-1:0]        entry,
  output logic                              better
);
  import npcs_pkg::*;

  logic [COLOR_W-1:0] cr, cg, cb;
  logic [COLOR_W-1:0] dr, dg, db;
  logic [MUL_W-1:0]   a_op, b_op;
  logic [PROD_W-1:0]  prod_r;
  logic [MUL_W-1:0]   acc_r, mag_r, dot_r, best_den_r;
  logic [PROD_W-1:0]  dsq_r, lhs_lo_r, rhs_lo_r, best_num_r;
  logic [CROSS_W-1:0] lhs_r;
  logic [MUL_W-1:0]   acc_sum;
  logic [CROSS_W-1:0] rhs;
  logic               eu_better, co_better;

  assign cr = entry[RGB_W-1 -: COLOR_W];
  assign cg = entry[2*COLOR_W-1 -: COLOR_W];
  assign cb = entry[COLOR_W-1:0];

  assign dr = (pixel_red > cr) ? (pixel_red - cr) : (cr - pixel_red);
  assign dg = (pixel_green > cg) ? (pixel_green - cg) : (cg - pixel_green);
  assign db = (pixel_blue > cb) ? (pixel_blue - cb) : (cb - pixel_blue);

  assign acc_sum = acc_r + prod_r[MUL_W-1:0];
  assign rhs     = {prod_r, MUL_W'(0)} + CROSS_W'(rhs_lo_r);

  assign eu_better = !ctrl.found || (PROD_W'(acc_sum) < best_num_r);
  assign co_better = !ctrl.found || (lhs_r > rhs);
  assign better    = ctrl.cosine ? ((ctrl.step == CO_CMP) && co_better)
                                 : ((ctrl.step == EU_SUM) && eu_better);

  // multiplier operand select
  always_comb begin
    a_op = '0;
    b_op = '0;
    if (ctrl.cosine) begin
      case (ctrl.step)
        CO_MAG_R: begin
          a_op = MUL_W'(cr);
          b_op = MUL_W'(cr);
        end
        CO_MAG_G: begin
          a_op = MUL_W'(cg);
          b_op = MUL_W'(cg);
        end
        CO_MAG_B: begin
          a_op = MUL_W'(cb);
          b_op = MUL_W'(cb);
        end
        CO_DOT_R: begin
          a_op = MUL_W'(pixel_red);
          b_op = MUL_W'(cr);
        end
        CO_DOT_G: begin
          a_op = MUL_W'(pixel_green);
          b_op = MUL_W'(cg);
        end
        CO_DOT_B: begin
          a_op = MUL_W'(pixel_blue);
          b_op = MUL_W'(cb);
        end
        CO_DOT_SQ: begin
          a_op = dot_r;
          b_op = dot_r;
        end
        CO_LHS_LO: begin
          a_op = prod_r[MUL_W-1:0];
          b_op = best_den_r;
        end
        CO_LHS_HI: begin
          a_op = dsq_r[PROD_W-1:MUL_W];
          b_op = best_den_r;
        end
        CO_RHS_LO: begin
          a_op = best_num_r[MUL_W-1:0];
          b_op = mag_r;
        end
        CO_RHS_HI: begin
          a_op = best_num_r[PROD_W-1:MUL_W];
          b_op = mag_r;
        end
        default: ;
      endcase
    end else begin
      case (ctrl.step)
        EU_SQ_R: begin
          a_op = MUL_W'(dr);
          b_op = MUL_W'(dr);
        end
        EU_SQ_G: begin
          a_op = MUL_W'(dg);
          b_op = MUL_W'(dg);
        end
        EU_SQ_B: begin
          a_op = MUL_W'(db);
          b_op = MUL_W'(db);
        end
        default: ;
      endcase
    end
  end

  // each step collects the product issued by the step before it
  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
    if (ctrl.cosine) begin
      case (ctrl.step)
        CO_MAG_G:   acc_r <= prod_r[MUL_W-1:0];
        CO_MAG_B:   acc_r <= acc_sum;
        CO_DOT_R:   mag_r <= acc_sum;
        CO_DOT_G:   acc_r <= prod_r[MUL_W-1:0];
        CO_DOT_B:   acc_r <= acc_sum;
        CO_DOT_SUM: dot_r <= acc_sum;
        CO_LHS_LO:  dsq_r <= prod_r;
        CO_LHS_HI:  lhs_lo_r <= prod_r;
        CO_RHS_LO:  lhs_r <= {prod_r, MUL_W'(0)} + CROSS_W'(lhs_lo_r);
        CO_RHS_HI:  rhs_lo_r <= prod_r;
        CO_CMP: begin
          if (better) begin
            best_num_r <= dsq_r;
            best_den_r <= mag_r;
          end
        end
        default: ;
      endcase
    end else begin
      case (ctrl.step)
        EU_SQ_G: acc_r <= prod_r[MUL_W-1:0];
        EU_SQ_B: acc_r <= acc_sum;
        EU_SUM: begin
          if (better) begin
            best_num_r <= PROD_W'(acc_sum);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/nearest_palette_color_search.sv
// top level of the nearest palette color search: handshakes, config registers, sequencer
// depends on npcs_pkg and npcs_dist_unit
//
// usage
//   in channel: in_valid/in_stall with one rgb pixel per item; in_stall is high from the
//   accepted item until its result has been moved into the output register
//   out channel: out_valid/out_stall with index, no-match flag and palette color per item;
//   the output register holds while out_stall is high, and a new pixel may be taken while
//   an older result still waits there
//   cfg channel: cfg_valid/cfg_ready, always ready; index 0 palette select, 1 distance mode
// timing
//   one shared 18x18 multiplier visits the entries in index order
//   euclidean: steps EU_SQ_R, EU_SQ_G, EU_SQ_B and EU_SUM for each entry of the 16-entry or PALETTE_DEPTH palette
//   cosine: steps CO_MAG_R through CO_CMP for each non-black entry, and a black entry is passed
//   over with no compare; a black pixel in cosine mode goes straight to hold with no match
//   a result waits in the search unit while the output register is still stalled
// reset
//   synchronous active-low reset clears both config registers, the sequencer and out_valid
`default_nettype none

module nearest_palette_color_search #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  npcs_pkg::cfg_idx_t            cfg_index,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [npcs_pkg::COLOR_W-1:0]  in_pixel_red,
  input  logic [npcs_pkg::COLOR_W-1:0]  in_pixel_green,
  input  logic [npcs_pkg::COLOR_W-1:0]  in_pixel_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [npcs_pkg::COLOR_W-1:0]  out_palette_index,
  output logic                          out_no_match,
  output logic [npcs_pkg::COLOR_W-1:0]  out_match_red,
  output logic [npcs_pkg::COLOR_W-1:0]  out_match_green,
  output logic [npcs_pkg::COLOR_W-1:0]  out_match_blue
);
  import npcs_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               palette_select_r, palette_select_nxt;
  logic               distance_mode_r, distance_mode_nxt;
  logic [COLOR_W-1:0] pix_red_r, pix_red_nxt;
  logic [COLOR_W-1:0] pix_green_r, pix_green_nxt;
  logic [COLOR_W-1:0] pix_blue_r, pix_blue_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  step_t              step_r, step_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [RGB_W-1:0]   best_col_r, best_col_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_index_r, out_index_nxt;
  logic               out_no_match_r, out_no_match_nxt;
  logic [RGB_W-1:0]   out_col_r, out_col_nxt;

  logic [RGB_W-1:0]   entry;
  logic [IDX_W-1:0]   last_idx;
  step_t              last_step;
  logic               better;
  logic               advance;
  logic               out_free;
  dist_ctrl_t         dctrl;

  assign entry     = palette_color(COLOR_W'(idx_r));
  assign last_idx  = palette_select_r ? IDX_W'(SHORT_DEPTH - 1) : IDX_W'(PALETTE_DEPTH - 1);
  assign last_step = distance_mode_r ? CO_CMP : EU_SUM;
  assign out_free  = !out_valid_r || !out_stall;

  assign dctrl.step   = step_r;
  assign dctrl.cosine = distance_mode_r;
  assign dctrl.found  = found_r;

  npcs_dist_unit u_dist (
    .clk         (clk),
    .ctrl        (dctrl),
    .pixel_red   (pix_red_r),
    .pixel_green (pix_green_r),
    .pixel_blue  (pix_blue_r),
    .entry       (entry),
    .better      (better)
  );

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_palette_index = out_index_r;
  assign out_no_match      = out_no_match_r;
  assign out_match_red     = out_col_r[RGB_W-1 -: COLOR_W];
  assign out_match_green   = out_col_r[2*COLOR_W-1 -: COLOR_W];
  assign out_match_blue    = out_col_r[COLOR_W-1:0];

  always_comb begin
    state_nxt          = state_r;
    palette_select_nxt = palette_select_r;
    distance_mode_nxt  = distance_mode_r;
    pix_red_nxt        = pix_red_r;
    pix_green_nxt      = pix_green_r;
    pix_blue_nxt       = pix_blue_r;
    idx_nxt            = idx_r;
    step_nxt           = step_r;
    found_nxt          = found_r;
    best_idx_nxt       = best_idx_r;
    best_col_nxt       = best_col_r;
    out_valid_nxt      = out_valid_r;
    out_index_nxt      = out_index_r;
    out_no_match_nxt   = out_no_match_r;
    out_col_nxt        = out_col_r;
    advance            = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PALETTE_SELECT: palette_select_nxt = cfg_data;
        CFG_DISTANCE_MODE:  distance_mode_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pix_red_nxt   = in_pixel_red;
          pix_green_nxt = in_pixel_green;
          pix_blue_nxt  = in_pixel_blue;
          idx_nxt       = '0;
          step_nxt      = '0;
          found_nxt     = 1'b0;
          // a black pixel has no direction in cosine mode
          if (distance_mode_r && ((in_pixel_red | in_pixel_green | in_pixel_blue) == '0)) begin
            state_nxt = ST_HOLD;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (distance_mode_r && (entry == '0)) begin
          advance = 1'b1;
        end else if (step_r == last_step) begin
          if (better) begin
            found_nxt    = 1'b1;
            best_idx_nxt = idx_r;
            best_col_nxt = entry;
          end
          step_nxt = '0;
          advance  = 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
        if (advance) begin
          if (idx_r == last_idx) begin
            state_nxt = ST_HOLD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_index_nxt    = COLOR_W'(best_idx_r);
            out_no_match_nxt = 1'b0;
            out_col_nxt      = best_col_r;
          end else begin
            out_index_nxt    = NO_MATCH_INDEX;
            out_no_match_nxt = 1'b1;
            out_col_nxt      = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      palette_select_r <= 1'b0;
      distance_mode_r  <= 1'b0;
      idx_r            <= '0;
      step_r           <= '0;
      found_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      palette_select_r <= palette_select_nxt;
      distance_mode_r  <= distance_mode_nxt;
      idx_r            <= idx_nxt;
      step_r           <= step_nxt;
      found_r          <= found_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_red_r      <= pix_red_nxt;
    pix_green_r    <= pix_green_nxt;
    pix_blue_r     <= pix_blue_nxt;
    best_idx_r     <= best_idx_nxt;
    best_col_r     <= best_col_nxt;
    out_index_r    <= out_index_nxt;
    out_no_match_r <= out_no_match_nxt;
    out_col_r      <= out_col_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted item did not start a search");

  a_no_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_no_match_r |->
      out_index_r == NO_MATCH_INDEX && out_col_r == '0)
    else $error("no-match result carries an index or color");

  a_no_match_cosine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_no_match_r |-> distance_mode_r)
    else $error("no-match result outside cosine mode");

  a_eu_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH && !distance_mode_r |-> step_r <= EU_SUM)
    else $error("euclidean step out of range");

  a_idle_step_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_SRCH |-> step_r == '0)
    else $error("step counter not cleared outside search");

endmodule

`default_nettype wire

>>> test/tb_nearest_palette_color_search.sv
// self-checking testbench for nearest_palette_color_search: random and directed pixels
// are checked against an independent palette search model, in both distance modes and depths
// depends on npcs_pkg and the nearest_palette_color_search rtl
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;
  import npcs_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 2400;
  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  localparam logic [23:0] CGA_COLORS [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500,
    24'hAAAAAA, 24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF,
    24'hFFFF55, 24'hFFFFFF
  };
  localparam logic [7:0] GRAY_STEPS [16] = '{
    8'd0, 8'd20, 8'd32, 8'd44, 8'd56, 8'd68, 8'd80, 8'd96,
    8'd112, 8'd128, 8'd144, 8'd160, 8'd180, 8'd200, 8'd224, 8'd252
  };
  // low, three ramp steps, high for each 24-entry hue wheel
  localparam logic [39:0] HUE_LEVELS [5] = '{
    {8'd0, 8'd64, 8'd124, 8'd188, 8'd252},
    {8'd124, 8'd156, 8'd188, 8'd220, 8'd252},
    {8'd180, 8'd196, 8'd220, 8'd236, 8'd252},
    {8'd0, 8'd28, 8'd56, 8'd84, 8'd112},
    {8'd56, 8'd68, 8'd84, 8'd96, 8'd112}
  };
  localparam logic [23:0] EDGE_PIXELS [12] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h0000AA,
    24'h5555FF, 24'hAA5500, 24'hFCFCFC, 24'h000055, 24'h808080, 24'h010000
  };

  typedef struct packed {
    logic [7:0] pal_index;
    logic       no_match;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_PALETTE_SELECT;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_pixel_red = '0;
  logic [7:0] in_pixel_green = '0;
  logic [7:0] in_pixel_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_palette_index;
  logic out_no_match;
  logic [7:0] out_match_red;
  logic [7:0] out_match_green;
  logic [7:0] out_match_blue;

  logic short_palette = 1'b0;
  logic cosine_mode = 1'b0;
  logic no_idle = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic [3:0] gap_left = '0;
  logic [3:0] stall_left = '0;

  logic [23:0] pixels_to_send [$];
  match_t expected_matches [$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned results_checked = 0;
  int unsigned no_match_seen = 0;
  int unsigned mismatches = 0;

  nearest_palette_color_search #(.PALETTE_DEPTH(PAL_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel_red(in_pixel_red),
    .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_palette_index(out_palette_index),
    .out_no_match(out_no_match),
    .out_match_red(out_match_red),
    .out_match_green(out_match_green),
    .out_match_blue(out_match_blue)
  );

  initial forever #2 clk = ~clk;

  function automatic logic [23:0] vga_color(int unsigned idx);
    logic [7:0] lv [5];
    logic [7:0] up;
    logic [7:0] down;
    int unsigned k;
    int unsigned st;
    if (idx < 16) return CGA_COLORS[idx];
    if (idx < 32) return {3{GRAY_STEPS[idx - 16]}};
    if (idx >= 168) return '0;
    if (idx >= 152) return {3{8'((idx - 152) * 16)}};
    for (int j = 0; j < 5; j++) begin
      lv[j] = HUE_LEVELS[(idx - 32) / 24][39 - 8 * j -: 8];
    end
    k = (idx - 32) % 24;
    st = k % 4;
    up = lv[st];
    down = lv[4 - st];
    case (k / 4)
      0: return {up, lv[0], lv[4]};
      1: return {lv[4], lv[0], down};
      2: return {lv[4], up, lv[0]};
      3: return {down, lv[4], lv[0]};
      4: return {lv[0], lv[4], up};
      default: return {lv[0], down, lv[4]};
    endcase
  endfunction

  function automatic match_t search_palette(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
    longint unsigned r, g, b, cr, cg, cb;
    longint unsigned score, mag, dot, best_num, best_den;
    longint dr, dg, db;
    logic [23:0] c;
    int depth;
    int unsigned best;
    bit found;
    match_t m;
    r = pr;
    g = pg;
    b = pb;
    depth = short_palette ? SHORT_DEPTH : PAL_DEPTH;
    found = 1'b0;
    best = 0;
    best_num = 0;
    best_den = 1;
    for (int j = 0; j < depth; j++) begin
      c = vga_color(j);
      cr = c[23:16];
      cg = c[15:8];
      cb = c[7:0];
      if (cosine_mode) begin
        mag = cr * cr + cg * cg + cb * cb;
        dot = r * cr + g * cg + b * cb;
        if (mag != 0 && (r | g | b) != 0) begin
          score = dot * dot;
          if (!found || score * best_den > best_num * mag) begin
            found = 1'b1;
            best = j;
            best_num = score;
            best_den = mag;
          end
        end
      end else begin
        dr = longint'(r) - longint'(cr);
        dg = longint'(g) - longint'(cg);
        db = longint'(b) - longint'(cb);
        score = longint'(dr * dr + dg * dg + db * db);
        if (!found || score < best_num) begin
          found = 1'b1;
          best = j;
          best_num = score;
        end
      end
    end
    if (found) begin
      c = vga_color(best);
      m.pal_index = 8'(best);
      m.no_match = 1'b0;
      {m.red, m.green, m.blue} = c;
    end else begin
      m.pal_index = NO_MATCH_INDEX;
      m.no_match = 1'b1;
      {m.red, m.green, m.blue} = '0;
    end
    return m;
  endfunction

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return vga_color($urandom_range(0, 255));
      1: return {3{8'($urandom_range(0, 255))}};
      2: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PALETTE_SELECT) short_palette = val;
    else if (idx == CFG_DISTANCE_MODE) cosine_mode = val;
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) begin
      pixels_to_send.push_back(random_pixel());
      queued_total++;
    end
  endtask

  task automatic queue_edge_pixels();
    foreach (EDGE_PIXELS[i]) begin
      pixels_to_send.push_back(EDGE_PIXELS[i]);
      queued_total++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (accepted_total != queued_total || expected_matches.size() != 0);
  endtask

  always @(posedge clk) begin : pixel_feed
    logic [23:0] px;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_matches.push_back(search_palette(in_pixel_red, in_pixel_green, in_pixel_blue));
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1'b1;
          in_valid <= 1'b0;
        end else if (pixels_to_send.size() != 0) begin
          px = pixels_to_send.pop_front();
          in_valid <= 1'b1;
          {in_pixel_red, in_pixel_green, in_pixel_blue} <= px;
          gap_left <= no_idle ? 4'd0 : 4'($urandom_range(0, 15));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [3:0] wait_draw;
    match_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= '0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (out_no_match) no_match_seen++;
        if (expected_matches.size() == 0) begin
          $error("result with no pixel outstanding: index %0d", out_palette_index);
          mismatches++;
        end else begin
          want = expected_matches.pop_front();
          check_field("palette_index", want.pal_index, out_palette_index);
          check_field("no_match", want.no_match, out_no_match);
          check_field("match_red", want.red, out_match_red);
          check_field("match_green", want.green, out_match_green);
          check_field("match_blue", want.blue, out_match_blue);
        end
      end
      if (hold_request && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        wait_draw = no_idle ? 4'd0 : 4'($urandom_range(0, 15));
        out_stall <= (wait_draw != 0);
        stall_left <= (wait_draw != 0) ? wait_draw - 1'b1 : 4'd0;
      end else if (stall_left != 0) begin
        if (out_valid) stall_left <= stall_left - 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // full palette, euclidean
    queue_edge_pixels();
    queue_random(100);
    wait_drained();

    // short palette, euclidean; receiver holds off while the sender keeps going
    write_reg(CFG_PALETTE_SELECT, 1'b1);
    no_idle <= 1'b1;
    hold_request <= 1'b1;
    queue_random(400);
    wait_drained();
    no_idle <= 1'b0;
    queue_random(400);
    wait_drained();

    // full palette, cosine
    write_reg(CFG_PALETTE_SELECT, 1'b0);
    write_reg(CFG_DISTANCE_MODE, 1'b1);
    queue_edge_pixels();
    queue_random(60);
    wait_drained();

    // short palette, cosine; writes past the register map must change nothing
    write_reg(CFG_PALETTE_SELECT, 1'b1);
    write_reg(CFG_SPARE_2, 1'b0);
    write_reg(CFG_SPARE_3, 1'b0);
    queue_random(450);
    wait_drained();
    queue_random(450);
    wait_drained();

    // back to the reset setting
    write_reg(CFG_DISTANCE_MODE, 1'b0);
    write_reg(CFG_PALETTE_SELECT, 1'b0);
    queue_random(40);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_matches.size() != 0) begin
      $error("%0d expected results never arrived", expected_matches.size());
    end
    $display("searched %0d pixels across both distance modes and both palette depths",
             results_checked);
    $display("%0d of those came back with no match", no_match_seen);
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_matches.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
